// ===== rtl/core/msls_pkg.sv =====
// Package for the movie script loop sequencer: input kinds, status and error codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package msls_pkg;
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd1;
  localparam logic [1:0] KIND_REQUEST = 2'd2;
  localparam logic [1:0] KIND_CMD     = 2'd3;

  localparam logic [31:0] OP_SEGMENT = 32'd0;
  localparam logic [31:0] OP_LOOP    = 32'd1;
  localparam logic [31:0] OP_ENDLOOP = 32'd2;
  localparam logic [31:0] OP_STOP    = 32'd3;
  localparam logic [31:0] OP_RESTART = 32'd4;
  localparam logic [31:0] OP_AUDIO   = 32'd5;

  localparam logic [2:0] ST_FETCH    = 3'd0;
  localparam logic [2:0] ST_SEGMENT  = 3'd1;
  localparam logic [2:0] ST_AUDIO    = 3'd2;
  localparam logic [2:0] ST_CHANGED  = 3'd3;
  localparam logic [2:0] ST_STOPPED  = 3'd4;
  localparam logic [2:0] ST_ERROR    = 3'd5;
  localparam logic [2:0] ST_ACCEPTED = 3'd6;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_TRUNCATED = 4'd1;
  localparam logic [3:0] ERR_RANGE     = 4'd2;
  localparam logic [3:0] ERR_LOOP      = 4'd3;
  localparam logic [3:0] ERR_EMPTY     = 4'd4;
  localparam logic [3:0] ERR_NAME      = 4'd5;
  localparam logic [3:0] ERR_UNKNOWN   = 4'd6;
  localparam logic [3:0] ERR_BUDGET    = 4'd7;
  localparam logic [3:0] ERR_ENTRY     = 4'd8;

  localparam logic [31:0] WIDE_STRIDE   = 32'd276;
  localparam logic [31:0] NARROW_STRIDE = 32'd12;
  localparam logic [31:0] AUDIO_RESET   = 32'd265;

  localparam logic [1:0] CFG_WIDE   = 2'd0;
  localparam logic [1:0] CFG_FILE   = 2'd1;
  localparam logic [1:0] CFG_ENTRY  = 2'd2;
  localparam logic [1:0] CFG_BUDGET = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/core/movie_script_loop_sequencer.sv =====
// Movie script loop sequencer top level: request decode, offset table and loop stack
// memories, result register. Depends on msls_pkg.
//
// Usage: load the entry-offset table with kind 0 requests, start an entry (kind 1),
// post change requests (kind 2) and feed the command found at fetch_address (kind 3).
// Every request yields one result on the out_ channel.
// Channels: in_/out_ with valid and stall; cfg_ write port with valid/ready, index
// selects wide_commands, file_bytes, entry_total, step_budget in that order.
// Timing: a taken request is captured while the offset table and stack top are read
// (synchronous memories); the step logic uses them while busy_r is set and the result
// is registered. A new request is not taken while busy_r is set, because of the stack-top
// read-modify-write and the table read. The next request can be taken in the same cycle
// as the waiting result is accepted.
// Reset: control state cleared, audio pointer 265, entry_total 1, budget 10000.
// in_stall is held high while rst_n is low.
// The table and stack are not cleared: an unloaded entry must not be started.
// Receiver stall: the result holds and in_stall stays high until out_ drains.
`timescale 1ns / 1ps
`default_nettype none
module movie_script_loop_sequencer
  import msls_pkg::*;
#(
  parameter int LOOP_DEPTH  = 64,
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_entry_index,
  input  wire logic [31:0] in_entry_offset,
  input  wire logic [31:0] in_opcode,
  input  wire logic [31:0] in_arg_a,
  input  wire logic [31:0] in_arg_b,
  input  wire logic        in_name_terminated,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [3:0]       out_error_code,
  output logic [31:0]      out_fetch_address,
  output logic [30:0]      out_segment_first,
  output logic [30:0]      out_segment_last,
  output logic [31:0]      out_audio_address,
  output logic [7:0]       out_current_entry,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int SW = $clog2(LOOP_DEPTH + 1);
  localparam int AW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
  localparam int TW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [SW-1:0] DEPTH_MAX = SW'(LOOP_DEPTH);

  // configuration
  logic        wide_r;
  logic [31:0] file_bytes_r;
  logic [8:0]  entry_total_r;
  logic [15:0] budget_r;

  // memories
  logic [31:0] table_mem [MAX_ENTRIES];
  logic [63:0] stack_mem [LOOP_DEPTH];
  logic [31:0] table_q_r;
  logic [63:0] stack_q_r;

  // state
  logic [31:0] cptr_r, estart_r, audio_r;
  logic [7:0]  playing_r, wanted_r;
  logic        pending_r;
  logic [SW-1:0] depth_r;
  logic [3:0]  sticky_r;
  logic [15:0] used_r;

  // captured request
  logic        busy_r;
  logic [1:0]  kind_r;
  logic [7:0]  idx_r;
  logic [31:0] op_r, a_r, b_r;
  logic        term_r;

  // output register
  logic        ov_r;
  logic [2:0]  st_r;
  logic [3:0]  ec_r;
  logic [30:0] sf_r, sl_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = ~rst_n | busy_r | (ov_r & out_stall);
  wire   take = in_valid & ~in_stall;

  // table read index: start picks in_entry_index, otherwise a switch picks wanted
  logic [7:0] rd_entry;
  assign rd_entry = (in_kind == KIND_START) ? in_entry_index : wanted_r;
  logic rd_entry_ok_r;
  logic [AW-1:0] top_a;
  assign top_a = AW'(depth_r - SW'(1));

  always_ff @(posedge clk) begin
    if (take && in_kind == KIND_LOAD && 32'(in_entry_index) < MAX_ENTRIES)
      table_mem[TW'(in_entry_index)] <= in_entry_offset;
    table_q_r <= table_mem[TW'(rd_entry)];
    rd_entry_ok_r <= 32'(rd_entry) < MAX_ENTRIES;
    stack_q_r <= stack_mem[top_a];
  end

  // step logic while busy_r is set
  logic [31:0] stride, nxt_ptr, offs, left, ret;
  logic [2:0]  st_n;
  logic [3:0]  ec_n;
  logic [30:0] sf_n, sl_n;
  logic [31:0] cptr_nxt, estart_nxt, audio_nxt;
  logic [7:0]  playing_nxt, wanted_nxt;
  logic        pending_nxt, pick, count_step, clr_used;
  logic [SW-1:0] depth_nxt;
  logic [3:0]  sticky_nxt;
  logic [15:0] used_nxt, used_inc;
  logic        push, wr_top;
  logic [63:0] wr_data;
  logic [AW-1:0] wr_a;

  assign offs   = rd_entry_ok_r ? table_q_r : 32'd0;
  assign left   = stack_q_r[31:0];
  assign ret    = stack_q_r[63:32];
  assign stride = wide_r ? WIDE_STRIDE : NARROW_STRIDE;
  assign nxt_ptr = cptr_r + stride;
  assign used_inc = used_r + 16'd1;

  always_comb begin
    st_n = ST_FETCH; ec_n = ERR_NONE; sf_n = '0; sl_n = '0;
    cptr_nxt = cptr_r; estart_nxt = estart_r; audio_nxt = audio_r;
    playing_nxt = playing_r; wanted_nxt = wanted_r; pending_nxt = pending_r;
    depth_nxt = depth_r; sticky_nxt = sticky_r; used_nxt = used_r;
    pick = 1'b0; count_step = 1'b0; clr_used = 1'b0;
    push = 1'b0; wr_top = 1'b0; wr_data = '0;
    unique case (kind_r)
      KIND_LOAD: st_n = ST_ACCEPTED;
      KIND_START: begin
        depth_nxt = '0; pending_nxt = 1'b0; sticky_nxt = ERR_NONE; used_nxt = '0;
        audio_nxt = AUDIO_RESET; cptr_nxt = '0; estart_nxt = '0;
        playing_nxt = '0; wanted_nxt = '0;
        if (9'(idx_r) >= entry_total_r) begin
          st_n = ST_ERROR; ec_n = ERR_ENTRY; sticky_nxt = ERR_ENTRY;
        end else begin
          playing_nxt = idx_r; wanted_nxt = idx_r; estart_nxt = offs; cptr_nxt = offs;
        end
      end
      KIND_REQUEST: begin
        if (9'(idx_r) >= entry_total_r) begin
          st_n = ST_ERROR; ec_n = ERR_ENTRY; sticky_nxt = ERR_ENTRY;
        end else begin
          st_n = ST_ACCEPTED;
          if (idx_r != playing_r) begin
            wanted_nxt = idx_r; pending_nxt = 1'b1;
          end
        end
      end
      default: begin
        if (sticky_r != ERR_NONE) begin
          st_n = ST_ERROR; ec_n = sticky_r;
        end else if (cptr_r > file_bytes_r || (file_bytes_r - cptr_r) < stride) begin
          st_n = ST_ERROR; ec_n = ERR_TRUNCATED;
        end else begin
          cptr_nxt = nxt_ptr;
          unique case (op_r)
            OP_SEGMENT: begin
              if (a_r[31] || $signed(b_r) <= $signed(a_r)) begin
                st_n = ST_ERROR; ec_n = ERR_RANGE;
              end else begin
                st_n = ST_SEGMENT; sf_n = a_r[30:0]; sl_n = b_r[30:0]; clr_used = 1'b1;
              end
            end
            OP_LOOP: begin
              if (depth_r >= DEPTH_MAX || a_r[31]) begin
                st_n = ST_ERROR; ec_n = ERR_LOOP;
              end else begin
                push = 1'b1; wr_data = {nxt_ptr, a_r - 32'd1};
                depth_nxt = depth_r + SW'(1); count_step = 1'b1;
              end
            end
            OP_ENDLOOP: begin
              if (depth_r == '0 || depth_r > DEPTH_MAX) begin
                st_n = ST_ERROR; ec_n = ERR_EMPTY;
              end else begin
                count_step = 1'b1;
                if (left == 32'd0) depth_nxt = depth_r - SW'(1);
                else if (left == 32'hFFFF_FFFF && pending_r) pick = 1'b1;
                else begin
                  if (!left[31]) begin
                    wr_top = 1'b1; wr_data = {ret, left - 32'd1};
                  end
                  cptr_nxt = ret;
                end
              end
            end
            OP_STOP: begin
              clr_used = 1'b1;
              if (pending_r) begin
                pick = 1'b1; st_n = ST_CHANGED;
              end else st_n = ST_STOPPED;
            end
            OP_RESTART: begin
              count_step = 1'b1;
              if (pending_r) pick = 1'b1;
              else cptr_nxt = estart_r;
            end
            OP_AUDIO: begin
              if (wide_r && !term_r) begin
                st_n = ST_ERROR; ec_n = ERR_NAME;
              end else begin
                if (wide_r) audio_nxt = cptr_r + NARROW_STRIDE;
                st_n = ST_AUDIO; clr_used = 1'b1;
              end
            end
            default: begin
              st_n = ST_ERROR; ec_n = ERR_UNKNOWN;
            end
          endcase
          if (pick) begin
            playing_nxt = wanted_r; estart_nxt = offs; cptr_nxt = offs;
            pending_nxt = 1'b0; depth_nxt = '0;
          end
          if (clr_used) used_nxt = '0;
          if (count_step) begin
            used_nxt = used_inc;
            if (used_inc >= budget_r || used_inc == 16'd0) begin
              st_n = ST_ERROR; ec_n = ERR_BUDGET;
            end
          end
          if (st_n == ST_ERROR) sticky_nxt = ec_n;
        end
      end
    endcase
    if (st_n == ST_ERROR) begin
      push = 1'b0; wr_top = 1'b0;
    end
  end

  assign wr_a = push ? AW'(depth_r) : top_a;

  always_ff @(posedge clk) begin
    if (busy_r && (push || wr_top)) stack_mem[wr_a] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0; file_bytes_r <= '0; entry_total_r <= 9'd1; budget_r <= 16'd10000;
      busy_r <= 1'b0; ov_r <= 1'b0;
      cptr_r <= '0; estart_r <= '0; audio_r <= AUDIO_RESET;
      playing_r <= '0; wanted_r <= '0; pending_r <= 1'b0;
      depth_r <= '0; sticky_r <= ERR_NONE; used_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WIDE:   wide_r <= cfg_data[0];
          CFG_FILE:   file_bytes_r <= cfg_data;
          CFG_ENTRY:  entry_total_r <= cfg_data[8:0];
          CFG_BUDGET: budget_r <= cfg_data[15:0];
        endcase
      end
      if (ov_r && !out_stall) ov_r <= 1'b0;
      busy_r <= take;
      if (busy_r) begin
        ov_r <= 1'b1;
        cptr_r <= cptr_nxt; estart_r <= estart_nxt; audio_r <= audio_nxt;
        playing_r <= playing_nxt; wanted_r <= wanted_nxt; pending_r <= pending_nxt;
        depth_r <= depth_nxt; sticky_r <= sticky_nxt; used_r <= used_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r <= in_kind; idx_r <= in_entry_index; op_r <= in_opcode;
      a_r <= in_arg_a; b_r <= in_arg_b; term_r <= in_name_terminated;
    end
    if (busy_r) begin
      st_r <= st_n; ec_r <= ec_n; sf_r <= sf_n; sl_r <= sl_n;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = st_r;
  assign out_error_code    = ec_r;
  assign out_segment_first = sf_r;
  assign out_segment_last  = sl_r;
  assign out_fetch_address = cptr_r;
  assign out_audio_address = audio_r;
  assign out_current_entry = playing_r;
endmodule
`default_nettype wire
